// ===== rtl/hav_pkg.sv =====
package hav_pkg;

  // Pipeline geometry
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned FRONT_LAT    = 3;
  localparam int unsigned SC_LAT       = CORDIC_STEPS + 2;
  localparam int unsigned BACK_LAT     = SC_LAT + 5 + SQRT_STEPS + CORDIC_STEPS + 5;
  localparam int unsigned QUEUE_DEPTH  = 8;

  // Field widths
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned DIST_W   = 33;

  // Arithmetic constants
  localparam logic [30:0]          DEG2PH_MUL   = 31'd1527099483;
  localparam logic signed [32:0]   CORDIC_GAIN  = 33'sd652032874;
  localparam logic [31:0]          PI_Q30       = 32'd3373259426;
  localparam logic [RADIUS_W-1:0]  RADIUS_RESET = 23'd6378137;
  localparam logic [DIST_W-1:0]    DIST_MAX     = '1;

  // Four phases of one item, handed from front to back
  typedef struct packed {
    logic [31:0] lat_a;
    logic [31:0] lat_b;
    logic [31:0] dlat;
    logic [31:0] dlon;
  } phase_set_t;

  // Arctangent table, phase units (2^32 per turn)
  function automatic logic signed [31:0] atan_at(input int unsigned idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sh20000000;
      1:  v = 32'sh12E4051E;
      2:  v = 32'sh09FB385B;
      3:  v = 32'sh051111D4;
      4:  v = 32'sh028B0D43;
      5:  v = 32'sh0145D7E1;
      6:  v = 32'sh00A2F61E;
      7:  v = 32'sh00517C55;
      8:  v = 32'sh0028BE53;
      9:  v = 32'sh00145F2F;
      10: v = 32'sh000A2F98;
      11: v = 32'sh000517CC;
      12: v = 32'sh00028BE6;
      13: v = 32'sh000145F3;
      14: v = 32'sh0000A2FA;
      15: v = 32'sh0000517D;
      16: v = 32'sh000028BE;
      17: v = 32'sh0000145F;
      18: v = 32'sh00000A30;
      19: v = 32'sh00000518;
      20: v = 32'sh0000028C;
      21: v = 32'sh00000146;
      22: v = 32'sh000000A3;
      23: v = 32'sh00000051;
      24: v = 32'sh00000029;
      25: v = 32'sh00000014;
      26: v = 32'sh0000000A;
      27: v = 32'sh00000005;
      28: v = 32'sh00000003;
      29: v = 32'sh00000001;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/hav_front.sv =====
module hav_front import hav_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH,
  localparam int unsigned CW = $clog2(QueueDepth + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [30:0]       lat_a_i,
  input  logic [30:0]       lat_b_i,
  input  logic [31:0]       lon_a_i,
  input  logic [31:0]       lon_b_i,
  input  logic [CW-1:0]     q_count_i,
  output logic              push_o,
  output phase_set_t        push_data_o
);

  logic        v1_q, v2_q, v3_q;
  logic [32:0] mag_q  [4];
  logic        neg1_q [4];
  logic [63:0] prod_q [4];
  logic        neg2_q [4];
  logic [31:0] ph_q   [4];

  logic [32:0] val  [4];
  logic [31:0] ph_d [4];
  logic [CW:0] occ;
  logic        accept;

  // Hold off when queued plus in-flight items could fill the queue
  assign occ = (CW+1)'(q_count_i) + (CW+1)'(v1_q) + (CW+1)'(v2_q) + (CW+1)'(v3_q);
  assign busy   = occ >= (CW+1)'(QueueDepth);
  assign accept = start & ~busy;

  // Sign-extended angles and differences
  always_comb begin
    val[0] = {{2{lat_a_i[30]}}, lat_a_i};
    val[1] = {{2{lat_b_i[30]}}, lat_b_i};
    val[2] = {lat_b_i[30], lat_b_i[30], lat_b_i} - {lat_a_i[30], lat_a_i[30], lat_a_i};
    val[3] = {lon_b_i[31], lon_b_i} - {lon_a_i[31], lon_a_i};
  end

  // Round, scale and restore sign: latitudes by 2^30, half-differences by 2^31
  always_comb begin
    logic [64:0] rnd;
    logic [64:0] r;
    for (int k = 0; k < 4; k++) begin
      if (k < 2) begin
        rnd = {1'b0, prod_q[k]} + (65'd1 << 29);
        r   = rnd >> 30;
      end else begin
        rnd = {1'b0, prod_q[k]} + (65'd1 << 30);
        r   = rnd >> 31;
      end
      ph_d[k] = neg2_q[k] ? (32'd0 - r[31:0]) : r[31:0];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Magnitude, product and phase stages
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      neg1_q[k] <= val[k][32];
      mag_q[k]  <= val[k][32] ? (33'd0 - val[k]) : val[k];
      prod_q[k] <= mag_q[k] * DEG2PH_MUL;
      neg2_q[k] <= neg1_q[k];
      ph_q[k]   <= ph_d[k];
    end
  end

  assign push_o            = v3_q;
  assign push_data_o.lat_a = ph_q[0];
  assign push_data_o.lat_b = ph_q[1];
  assign push_data_o.dlat  = ph_q[2];
  assign push_data_o.dlon  = ph_q[3];

endmodule

// ===== rtl/hav_queue.sv =====
module hav_queue import hav_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH,
  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned CW = $clog2(QueueDepth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  phase_set_t    push_data_i,
  output logic          pop_o,
  output phase_set_t    pop_data_o,
  output logic [CW-1:0] count_o
);

  phase_set_t    mem_q [QueueDepth];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  // Back side never stalls: drain whenever an item is waiting
  assign pop_o      = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QueueDepth - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_o)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      count_q <= count_q + CW'(push_i) - CW'(pop_o);
    end
  end

  // Store item
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== rtl/hav_sincos.sv =====
module hav_sincos import hav_pkg::*; (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [32:0] x_q [CORDIC_STEPS+1];
  logic signed [32:0] y_q [CORDIC_STEPS+1];
  logic signed [31:0] z_q [CORDIC_STEPS+1];
  logic [1:0]         q_q [CORDIC_STEPS+1];

  logic [31:0] centered;
  logic [1:0]  quad;

  // Pick the nearest quarter turn, keep the residue
  assign centered = phase_i + 32'h2000_0000;
  assign quad     = centered[31:30];

  always_ff @(posedge clk_i) begin
    x_q[0] <= CORDIC_GAIN;
    y_q[0] <= '0;
    z_q[0] <= signed'(phase_i - {quad, 30'd0});
    q_q[0] <= quad;
  end

  // Rotation steps
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (!z_q[i][31]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - atan_at(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + atan_at(i);
      end
      q_q[i+1] <= q_q[i];
    end
  end

  // Rotate back by the quarter turns
  always_ff @(posedge clk_i) begin
    case (q_q[CORDIC_STEPS])
      2'd0: begin
        cos_o <= 32'(x_q[CORDIC_STEPS]);
        sin_o <= 32'(y_q[CORDIC_STEPS]);
      end
      2'd1: begin
        cos_o <= 32'(-y_q[CORDIC_STEPS]);
        sin_o <= 32'(x_q[CORDIC_STEPS]);
      end
      2'd2: begin
        cos_o <= 32'(-x_q[CORDIC_STEPS]);
        sin_o <= 32'(-y_q[CORDIC_STEPS]);
      end
      default: begin
        cos_o <= 32'(y_q[CORDIC_STEPS]);
        sin_o <= 32'(-x_q[CORDIC_STEPS]);
      end
    endcase
  end

endmodule

// ===== rtl/hav_back.sv =====
module hav_back import hav_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_i,
  input  phase_set_t          pop_data_i,
  input  logic [RADIUS_W-1:0] radius_i,
  output logic                done_o,
  output logic [DIST_W-1:0]   distance_o
);

  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

  logic [BACK_LAT-1:0] vld_q;

  logic signed [31:0] cos_a, cos_b, s_lat, s_lon;

  logic signed [63:0] prod_cc_q, sq1_q, sq2_q, sq3_q, ps_q, rs_q;
  logic signed [31:0] s_lon1_q, s_lon2_q;
  logic signed [31:0] p_w, r_w;
  logic signed [64:0] sum_w;
  logic [60:0]        a_q;

  logic [60:0] sv_q [2][SQRT_STEPS+1];
  logic [61:0] sr_q [2][SQRT_STEPS+1];

  logic signed [41:0] vx_q [CORDIC_STEPS];
  logic signed [41:0] vy_q [CORDIC_STEPS];
  logic signed [33:0] vz_q [CORDIC_STEPS];

  logic [31:0] zc_q;
  logic [63:0] prodw_q;
  logic [41:0] w_q;
  logic [64:0] rw_q;
  logic [34:0] d_w;

  // Track items through the fixed-latency pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[BACK_LAT-2:0], pop_i};
  end
  assign done_o = vld_q[BACK_LAT-1];

  // Four rotation pipelines
  hav_sincos u_sc_lat_a (.clk_i, .phase_i(pop_data_i.lat_a), .cos_o(cos_a), .sin_o());
  hav_sincos u_sc_lat_b (.clk_i, .phase_i(pop_data_i.lat_b), .cos_o(cos_b), .sin_o());
  hav_sincos u_sc_dlat  (.clk_i, .phase_i(pop_data_i.dlat),  .cos_o(),      .sin_o(s_lat));
  hav_sincos u_sc_dlon  (.clk_i, .phase_i(pop_data_i.dlon),  .cos_o(),      .sin_o(s_lon));

  // Haversine term: registered multiplies, then clamp to [0, 1]
  assign p_w   = prod_cc_q[61:30];
  assign r_w   = ps_q[61:30];
  assign sum_w = {sq3_q[63], sq3_q} + {rs_q[63], rs_q};

  always_ff @(posedge clk_i) begin
    prod_cc_q <= cos_a * cos_b;
    sq1_q     <= s_lat * s_lat;
    s_lon1_q  <= s_lon;
    ps_q      <= p_w * s_lon1_q;
    sq2_q     <= sq1_q;
    s_lon2_q  <= s_lon1_q;
    rs_q      <= r_w * s_lon2_q;
    sq3_q     <= sq2_q;
    if (sum_w[64])                 a_q <= '0;
    else if (sum_w[63:0] > ONE_Q60) a_q <= ONE_Q60[60:0];
    else                           a_q <= sum_w[60:0];
    sv_q[0][0] <= a_q;
    sv_q[1][0] <= ONE_Q60[60:0] - a_q;
    sr_q[0][0] <= '0;
    sr_q[1][0] <= '0;
  end

  // Square roots of a and 1 - a, one result bit per stage
  for (genvar l = 0; l < 2; l++) begin : g_root
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [61:0] BIT = 62'd1 << (60 - 2 * j);
      logic [61:0] rb;
      assign rb = sr_q[l][j] + BIT;
      always_ff @(posedge clk_i) begin
        if ({1'b0, sv_q[l][j]} >= rb) begin
          sv_q[l][j+1] <= sv_q[l][j] - rb[60:0];
          sr_q[l][j+1] <= (sr_q[l][j] >> 1) + BIT;
        end else begin
          sv_q[l][j+1] <= sv_q[l][j];
          sr_q[l][j+1] <= sr_q[l][j] >> 1;
        end
      end
    end
  end

  // Vectoring steps: angle of (sqrt(1-a), sqrt(a))
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [41:0] xi, yi;
    logic signed [33:0] zi;
    if (i == 0) begin : g_init
      assign xi = signed'({3'b0, sr_q[1][SQRT_STEPS][30:0], 8'd0});
      assign yi = signed'({3'b0, sr_q[0][SQRT_STEPS][30:0], 8'd0});
      assign zi = '0;
    end else begin : g_link
      assign xi = vx_q[i-1];
      assign yi = vy_q[i-1];
      assign zi = vz_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (!yi[41]) begin
        vx_q[i] <= xi + (yi >>> i);
        vy_q[i] <= yi - (xi >>> i);
        vz_q[i] <= zi + 34'(atan_at(i));
      end else begin
        vx_q[i] <= xi - (yi >>> i);
        vy_q[i] <= yi + (xi >>> i);
        vz_q[i] <= zi - 34'(atan_at(i));
      end
    end
  end

  // Scale angle to radians, then by the radius; saturate
  assign d_w = 35'((rw_q + 65'd536870912) >> 30);

  always_ff @(posedge clk_i) begin
    if (vz_q[CORDIC_STEPS-1][33])                         zc_q <= '0;
    else if (vz_q[CORDIC_STEPS-1] > 34'sh0_8000_0000)     zc_q <= 32'h8000_0000;
    else                                                  zc_q <= vz_q[CORDIC_STEPS-1][31:0];
    prodw_q <= zc_q * PI_Q30;
    w_q     <= 42'((prodw_q + 64'd2097152) >> 22);
    rw_q    <= radius_i * w_q;
    distance_o <= (d_w > {2'b0, DIST_MAX}) ? DIST_MAX : d_w[DIST_W-1:0];
  end

endmodule

// ===== rtl/haversine_great_circle_distance.sv =====
// Great-circle distance by the haversine formula.
//
// Issue an item by raising start with both points on lat_*/lon_* (degrees
// times 2^23); it is taken at a clock edge where busy is low. Each item gives
// one distance on distance_q8_o (meters times 2^8) marked by a one-cycle
// done_o pulse, in issue order. The receiver cannot hold results off, and no
// result is dropped.
//
// Throughput is one item per clock while busy is low. A three-stage front converts
// angles to phases and writes a small queue; the back drains it whenever it holds
// an item into fixed pipelines: four 32-stage sine/cosine rotators, the haversine
// multiplies, two 31-stage square-root pipelines, a 30-stage vectoring rotator and
// the final scaling. busy rises only when the queue plus front items in flight
// would fill the queue, which needs a depth of four or less.
//
// The radius is written on cfg_valid_i/cfg_ready_o/cfg_data_i, always ready;
// write it only while no item is in flight. Reset drops all items in flight
// and sets the radius to 6378137 m.
module haversine_great_circle_distance import hav_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [30:0]         lat_a_deg_i,
  input  logic [30:0]         lat_b_deg_i,
  input  logic [31:0]         lon_a_deg_i,
  input  logic [31:0]         lon_b_deg_i,
  output logic                done_o,
  output logic [DIST_W-1:0]   distance_q8_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RADIUS_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(QueueDepth + 1);

  logic [RADIUS_W-1:0] radius_q;
  logic                push, pop;
  phase_set_t          push_data, pop_data;
  logic [CW-1:0]       q_count;

  // Radius register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                         radius_q <= RADIUS_RESET;
    else if (cfg_valid_i && cfg_ready_o) radius_q <= cfg_data_i;
  end

  hav_front #(.QueueDepth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .start, .busy,
    .lat_a_i(lat_a_deg_i), .lat_b_i(lat_b_deg_i),
    .lon_a_i(lon_a_deg_i), .lon_b_i(lon_b_deg_i),
    .q_count_i(q_count), .push_o(push), .push_data_o(push_data)
  );

  hav_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .pop_o(pop), .pop_data_o(pop_data), .count_o(q_count)
  );

  hav_back u_back (
    .clk_i, .rst_ni, .pop_i(pop), .pop_data_i(pop_data), .radius_i(radius_q),
    .done_o, .distance_o(distance_q8_o)
  );

  // Queue never takes an item while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_count < CW'(QueueDepth)))
    else $error("queue overflow");

  // Every result strobe traces back to an item drained to the back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(pop, BACK_LAT))
    else $error("result strobe out of step with queue drain");

endmodule
